@@ hw/rtl/mbcm_pkg.sv @@
// shared types and constants of the memory block change monitor
`timescale 1ns / 1ps
`default_nettype none
package mbcm_pkg;

    localparam int SUM_W   = 32;
    localparam int CLEAN_W = 8;
    localparam int DIRTY_W = 5;
    localparam int BLK_W   = 7;
    localparam int PASS_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CLEAN_W-1:0] CLEAN_MAX = 8'd250;
    localparam logic [DIRTY_W-1:0] DIRTY_MAX = 5'd31;
    localparam logic [PASS_W-1:0]  PASS_MAX  = 8'd255;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_LIMIT       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQUENT_BELOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_LOW       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_HIGH      = 3'd4;

    localparam logic [CLEAN_W-1:0] RST_REPORT_THRESHOLD = 8'd10;
    localparam logic [DIRTY_W-1:0] RST_SKIP_LIMIT       = 5'd25;
    localparam logic [CLEAN_W-1:0] RST_FREQUENT_BELOW   = 8'd4;
    localparam logic [PASS_W-1:0]  RST_WARMUP_LOW       = 8'd2;
    localparam logic [PASS_W-1:0]  RST_WARMUP_HIGH      = 8'd30;

    localparam logic OP_INIT  = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    typedef struct packed {
        logic [CLEAN_W-1:0] report_threshold;
        logic [DIRTY_W-1:0] skip_limit;
        logic [CLEAN_W-1:0] frequent_below;
        logic [PASS_W-1:0]  warmup_low;
        logic [PASS_W-1:0]  warmup_high;
    } cfg_t;

    // per-block state held in the memory
    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [CLEAN_W-1:0] clean;
        logic [DIRTY_W-1:0] dirty;
    } entry_t;

    // item after the input register
    typedef struct packed {
        logic              op;
        logic              last;
        logic              in_range;
        logic [BLK_W-1:0]  block;
        logic [SUM_W-1:0]  sum;
        logic [PASS_W-1:0] pass;
    } item_t;

    // result, out_block in the lowest bits
    typedef struct packed {
        logic [CLEAN_W-1:0] prior_clean;
        logic               report;
        logic               changed;
        logic               skipped;
        logic [BLK_W-1:0]   out_block;
    } result_t;

    localparam int RES_W = $bits(result_t);

endpackage
`default_nettype wire

@@ hw/rtl/mbcm_front.sv @@
// running word sum and pass counter, updated on each input transfer
`timescale 1ns / 1ps
`default_nettype none
module mbcm_front
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic                        op,
    input  wire logic                        first_of_pass,
    input  wire logic                        last_word,
    input  wire logic [mbcm_pkg::SUM_W-1:0]  mem_word,
    output logic      [mbcm_pkg::SUM_W-1:0]  sum_now,
    output logic      [mbcm_pkg::PASS_W-1:0] pass_now,
    output logic      [mbcm_pkg::SUM_W-1:0]  running_sum
);
    import mbcm_pkg::*;

    logic [SUM_W-1:0]  running_sum_reg;
    logic [SUM_W-1:0]  running_sum_next;
    logic [PASS_W-1:0] pass_count_reg;
    logic [PASS_W-1:0] pass_count_next;

    always_comb
    begin
        sum_now = running_sum_reg + mem_word;
        pass_count_next = pass_count_reg;
        if (op == OP_CHECK && first_of_pass && pass_count_reg < PASS_MAX)
        begin
            pass_count_next = pass_count_reg + 8'd1;
        end
        running_sum_next = last_word ? '0 : sum_now;
    end

    assign pass_now    = pass_count_next;
    assign running_sum = running_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg <= '0;
            pass_count_reg  <= '0;
        end
        else if (accept)
        begin
            running_sum_reg <= running_sum_next;
            pass_count_reg  <= pass_count_next;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/mbcm_ram.sv @@
// per-block state memory, one read and one write port, write-through bypass
`timescale 1ns / 1ps
`default_nettype none
module mbcm_ram
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7
)
(
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output mbcm_pkg::entry_t       rd_data,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire mbcm_pkg::entry_t  wr_data
);
    import mbcm_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // a write to the address being read in the same cycle is passed through
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && wr_addr == rd_addr)
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ hw/rtl/mbcm_check.sv @@
// compare and count update, or initial entry write, for one closed block sum
`timescale 1ns / 1ps
`default_nettype none
module mbcm_check
(
    input  wire mbcm_pkg::item_t   item,
    input  wire mbcm_pkg::entry_t  entry,
    input  wire mbcm_pkg::cfg_t    cfg,
    output logic                   emit,
    output mbcm_pkg::result_t      result,
    output logic                   wr_en,
    output mbcm_pkg::entry_t       wr_data
);
    import mbcm_pkg::*;

    logic               skip;
    logic               changed;
    logic               rep;
    logic               warm;
    logic [DIRTY_W-1:0] dirty_new;
    logic [CLEAN_W-1:0] clean_new;

    always_comb
    begin
        skip    = !item.in_range || entry.dirty >= cfg.skip_limit;
        changed = entry.sum != item.sum;
        rep     = entry.clean >= cfg.report_threshold;
        warm    = item.pass > cfg.warmup_low && item.pass < cfg.warmup_high;

        dirty_new = entry.dirty;
        if (changed && !rep)
        begin
            if (entry.clean < cfg.frequent_below && entry.dirty < DIRTY_MAX)
            begin
                dirty_new = entry.dirty + 5'd1;
            end
            if (warm)
            begin
                dirty_new = cfg.skip_limit;
            end
        end

        if (changed)
        begin
            clean_new = '0;
        end
        else if (entry.clean < CLEAN_MAX)
        begin
            clean_new = entry.clean + 8'd1;
        end
        else
        begin
            clean_new = entry.clean;
        end

        emit = item.last && item.op == OP_CHECK;

        result.out_block   = item.block;
        result.skipped     = skip;
        result.changed     = !skip && changed;
        result.report      = !skip && changed && rep;
        result.prior_clean = skip ? '0 : entry.clean;

        if (item.op == OP_INIT)
        begin
            wr_en         = item.last && item.in_range;
            wr_data.sum   = item.sum;
            wr_data.clean = cfg.report_threshold;
            wr_data.dirty = '0;
        end
        else
        begin
            wr_en         = item.last && !skip;
            wr_data.sum   = item.sum;
            wr_data.clean = clean_new;
            wr_data.dirty = dirty_new;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/memory_block_change_monitor_top.sv @@
// top level of the memory block change monitor
`timescale 1ns / 1ps
`default_nettype none
// Takes one scanned word per cycle and gives one result per check word that
// closes a block: the input register and the state memory read come first,
// then the compare and count update, which writes the memory and loads the
// output register. The per-block state lives in a memory with one read and
// one write port; a write bypass lets words of the same block follow each
// other without a gap. The input stalls only while the output register is
// full, not taken, and a result waits behind it. Per-block state is undefined
// until an init word has closed the block; the user must write configuration
// only while no word is in flight, which the block itself does not enforce.
module memory_block_change_monitor_top
#(
    parameter int BLOCKS = 128
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // block_index[6:0], mem_word[38:7], zero pad
    input  wire logic        s_tlast,   // last_word
    input  wire logic [1:0]  s_tuser,   // op[0], first_of_pass[1]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // out_block[6:0], skipped[7], changed[8],
                                        // report[9], prior_clean[17:10], zero pad
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [mbcm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mbcm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mbcm_pkg::*;

    localparam int AW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;

    cfg_t    cfg_reg;
    item_t   s1_item_reg;
    logic    s1_valid_reg;
    result_t out_reg;
    logic    out_valid_reg;

    logic              s_accept;
    logic              s1_go;
    logic [BLK_W-1:0]  in_block;
    logic [SUM_W-1:0]  sum_now;
    logic [PASS_W-1:0] pass_now;
    logic [SUM_W-1:0]  running_sum;
    entry_t            rd_entry;
    logic              emit;
    result_t           result;
    logic              wr_en;
    entry_t            wr_data;

    assign in_block  = s_tdata[BLK_W-1:0];
    assign cfg_ready = 1'b1;

    // the stage moves on when its result finds room or it has none
    assign s1_go    = s1_valid_reg && (!emit || !out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_go;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.report_threshold <= RST_REPORT_THRESHOLD;
            cfg_reg.skip_limit       <= RST_SKIP_LIMIT;
            cfg_reg.frequent_below   <= RST_FREQUENT_BELOW;
            cfg_reg.warmup_low       <= RST_WARMUP_LOW;
            cfg_reg.warmup_high      <= RST_WARMUP_HIGH;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_REPORT_THRESHOLD: cfg_reg.report_threshold <= cfg_data;
                CFG_SKIP_LIMIT:       cfg_reg.skip_limit       <= cfg_data[DIRTY_W-1:0];
                CFG_FREQUENT_BELOW:   cfg_reg.frequent_below   <= cfg_data;
                CFG_WARMUP_LOW:       cfg_reg.warmup_low       <= cfg_data;
                CFG_WARMUP_HIGH:      cfg_reg.warmup_high      <= cfg_data;
                default: ;
            endcase
        end
    end

    mbcm_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (s_accept),
        .op            (s_tuser[0]),
        .first_of_pass (s_tuser[1]),
        .last_word     (s_tlast),
        .mem_word      (s_tdata[BLK_W +: SUM_W]),
        .sum_now       (sum_now),
        .pass_now      (pass_now),
        .running_sum   (running_sum)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_item_reg.op       <= s_tuser[0];
            s1_item_reg.last     <= s_tlast;
            s1_item_reg.in_range <= 32'(in_block) < 32'(BLOCKS);
            s1_item_reg.block    <= in_block;
            s1_item_reg.sum      <= sum_now;
            s1_item_reg.pass     <= pass_now;
        end
    end

    mbcm_ram
    #(
        .DEPTH (BLOCKS),
        .AW    (AW)
    )
    u_ram
    (
        .clk     (clk),
        .rd_en   (s_accept),
        .rd_addr (AW'(in_block)),
        .rd_data (rd_entry),
        .wr_en   (s1_go && wr_en),
        .wr_addr (AW'(s1_item_reg.block)),
        .wr_data (wr_data)
    );

    mbcm_check u_check
    (
        .item    (s1_item_reg),
        .entry   (rd_entry),
        .cfg     (cfg_reg),
        .emit    (emit),
        .result  (result),
        .wr_en   (wr_en),
        .wr_data (wr_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && emit)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(24 - RES_W)'(0), out_reg};

`ifndef SYNTHESIS
    a_skip_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.skipped |->
            !out_reg.changed && !out_reg.report && out_reg.prior_clean == '0)
        else $error("skipped block carries change data");

    a_report_changed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.report |-> out_reg.changed)
        else $error("report without change");

    a_sum_closes: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && s_tlast |=> running_sum == '0)
        else $error("running sum not cleared after last word");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_go |-> out_valid_reg && !m_tready && emit)
        else $error("stage held without a blocked result");

    a_pass_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> pass_now >= $past(pass_now))
        else $error("pass counter went backwards");
`endif

endmodule
`default_nettype wire
